// ===== sv/etl_pkg.sv =====
// Shared types and constants for the expression token lexer.
package etl_pkg;

   localparam int POSITION_BITS_DEF = 16;
   localparam int INDEX_BITS_DEF    = 10;
   localparam int CAP_BITS          = 10;

   localparam logic [4:0] K_INT   = 5'd0;
   localparam logic [4:0] K_IDENT = 5'd1;
   localparam logic [4:0] K_LP    = 5'd2;
   localparam logic [4:0] K_RP    = 5'd3;
   localparam logic [4:0] K_PLUS  = 5'd4;
   localparam logic [4:0] K_MINUS = 5'd5;
   localparam logic [4:0] K_STAR  = 5'd6;
   localparam logic [4:0] K_SLASH = 5'd7;
   localparam logic [4:0] K_PCT   = 5'd8;
   localparam logic [4:0] K_AND   = 5'd9;
   localparam logic [4:0] K_OR    = 5'd10;
   localparam logic [4:0] K_NOT   = 5'd11;
   localparam logic [4:0] K_EQ    = 5'd12;
   localparam logic [4:0] K_NE    = 5'd13;
   localparam logic [4:0] K_LT    = 5'd14;
   localparam logic [4:0] K_LE    = 5'd15;
   localparam logic [4:0] K_GT    = 5'd16;
   localparam logic [4:0] K_GE    = 5'd17;
   localparam logic [4:0] K_ERR   = 5'd18;
   localparam logic [4:0] K_EOF   = 5'd19;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } etl_req_type;

   typedef struct packed {
      logic [4:0]         out_kind;
      logic [15:0]        start_offset;
      logic [15:0]        token_len;
      logic signed [31:0] int_value;
      logic [9:0]         token_number;
      logic               beyond_cap;
      logic               is_final;
   } etl_rsp_type;

endpackage

// ===== sv/expression_token_lexer.sv =====
// Expression token lexer: one text character in, zero to three tokens out.
//
// Characters are taken one per transfer on the req_ channel; each transfer
// completes zero, one, two or three tokens, delivered one per transfer on the
// rsp_ channel. A character lands in an input register; once it is processed,
// the lexer state and the token group are computed into a three-entry token
// buffer, and its tokens leave from that buffer. An item that yields at most
// one token is taken every cycle while rsp_stall stays low; an item that
// yields two or three tokens holds the input side while the token buffer
// drains one token per cycle, or slower under rsp_stall. A character is
// processed only once the buffer is empty or its last token leaves.
// csr_wr_data sets token_cap (reset 128); write it only while idle.
module expression_token_lexer
   import etl_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int INDEX_BITS    = INDEX_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  etl_req_type         req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output etl_rsp_type         rsp_payload,
   input  logic                csr_wr_en,
   input  logic [CAP_BITS-1:0] csr_wr_data
);

   typedef enum logic [1:0] {MODE_IDLE, MODE_NUM, MODE_IDENT, MODE_OP} mode_type;

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [INDEX_BITS-1:0]    idx_type;

   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_AMP  = 3'd1;
   localparam logic [2:0] OP_BAR  = 3'd2;
   localparam logic [2:0] OP_BANG = 3'd3;
   localparam logic [2:0] OP_EQ   = 3'd4;
   localparam logic [2:0] OP_LT   = 3'd5;
   localparam logic [2:0] OP_GT   = 3'd6;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_LP    = 8'h28;
   localparam logic [7:0] CH_RP    = 8'h29;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   localparam logic [23:0] W_AND = 24'h616E64;
   localparam logic [23:0] W_OR  = 24'h006F72;
   localparam logic [23:0] W_NOT = 24'h6E6F74;
   localparam logic [23:0] W_EQ  = 24'h006571;
   localparam logic [23:0] W_NE  = 24'h006E65;
   localparam logic [23:0] W_LT  = 24'h006C74;
   localparam logic [23:0] W_LE  = 24'h006C65;
   localparam logic [23:0] W_GT  = 24'h006774;
   localparam logic [23:0] W_GE  = 24'h006765;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(128);

   // ---------------------------------------------------------------- helpers
   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             (c == 8'h5F);
   endfunction

   function automatic pos_type pos_inc(input pos_type v);
      return (v == '1) ? v : v + pos_type'(1);
   endfunction

   function automatic idx_type idx_inc(input idx_type v);
      return (v == '1) ? v : v + idx_type'(1);
   endfunction

   function automatic logic [15:0] pos_clamp(input pos_type v);
      logic [31:0] ext;
      ext = 32'(v);
      return (ext > 32'h0000FFFF) ? 16'hFFFF : ext[15:0];
   endfunction

   function automatic logic [7:0] op_second(input logic [2:0] p);
      logic [7:0] r;
      unique case (p)
         OP_AMP:                      r = CH_AMP;
         OP_BAR:                      r = CH_BAR;
         OP_BANG, OP_EQ, OP_LT, OP_GT: r = CH_EQ;
         default:                     r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] op_pair(input logic [2:0] p);
      logic [4:0] r;
      unique case (p)
         OP_AMP:  r = K_AND;
         OP_BAR:  r = K_OR;
         OP_BANG: r = K_NE;
         OP_EQ:   r = K_EQ;
         OP_LT:   r = K_LE;
         OP_GT:   r = K_GE;
         default: r = K_ERR;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] op_single(input logic [2:0] p);
      logic [4:0] r;
      unique case (p)
         OP_BANG: r = K_NOT;
         OP_LT:   r = K_LT;
         OP_GT:   r = K_GT;
         default: r = K_ERR;
      endcase
      return r;
   endfunction

   // keyword folding looks at the length and the first three characters
   function automatic logic [4:0] fold_keyword(input pos_type len, input logic [23:0] pre);
      logic [4:0] r;
      logic       l2;
      logic       l3;
      l2 = (len == pos_type'(2));
      l3 = (len == pos_type'(3));
      priority if (l3 && pre == W_AND) r = K_AND;
      else if (l2 && pre == W_OR)      r = K_OR;
      else if (l3 && pre == W_NOT)     r = K_NOT;
      else if (l2 && pre == W_EQ)      r = K_EQ;
      else if (l2 && pre == W_NE)      r = K_NE;
      else if (l2 && pre == W_LT)      r = K_LT;
      else if (l2 && pre == W_LE)      r = K_LE;
      else if (l2 && pre == W_GT)      r = K_GT;
      else if (l2 && pre == W_GE)      r = K_GE;
      else                             r = K_IDENT;
      return r;
   endfunction

   function automatic etl_rsp_type make_tok(input logic [4:0] kind, input pos_type start,
                                            input logic [15:0] len, input logic [31:0] val);
      etl_rsp_type t;
      t              = '0;
      t.out_kind     = kind;
      t.start_offset = pos_clamp(start);
      t.token_len    = len;
      t.int_value    = signed'(val);
      return t;
   endfunction

   function automatic etl_rsp_type flush_tok(input mode_type m, input logic [2:0] p,
                                             input logic [31:0] n, input pos_type b,
                                             input pos_type l, input logic [23:0] pre);
      etl_rsp_type t;
      unique case (m)
         MODE_NUM:   t = make_tok(K_INT, b, pos_clamp(l), n);
         MODE_IDENT: t = make_tok(fold_keyword(l, pre), b, pos_clamp(l), 32'd0);
         MODE_OP:    t = make_tok(op_single(p), b, 16'd1, 32'd0);
         default:    t = '0;
      endcase
      return t;
   endfunction

   // ---------------------------------------------------------------- registers
   logic                in_valid_ff, in_valid_in;
   etl_req_type         in_ff, in_in;
   mode_type            mode_ff, mode_in;
   logic [2:0]          pend_ff, pend_in;
   logic [31:0]         num_ff, num_in;
   pos_type             begin_ff, begin_in;
   pos_type             len_ff, len_in;
   logic [23:0]         prefix_ff, prefix_in;
   pos_type             pos_ff, pos_in;
   idx_type             tcnt_ff, tcnt_in;
   logic [CAP_BITS-1:0] cap_ff, cap_in;
   etl_rsp_type         buf_ff [3];
   etl_rsp_type         buf_in [3];
   logic [1:0]          cnt_ff, cnt_in;

   // ---------------------------------------------------------------- handshake
   logic req_xfer;
   logic rsp_xfer;
   logic process;

   assign rsp_valid   = (cnt_ff != 2'd0);
   assign rsp_payload = buf_ff[0];
   assign rsp_xfer    = rsp_valid && !rsp_stall;
   assign process     = in_valid_ff && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_xfer));
   assign req_stall   = in_valid_ff && !process;
   assign req_xfer    = req_valid && !req_stall;

   // ---------------------------------------------------------------- lexer step
   logic [7:0]  c;
   logic        fin;
   logic        cons;
   logic        ws;
   mode_type    mode_n;
   logic [2:0]  pend_n;
   logic [31:0] num_n;
   pos_type     begin_n;
   pos_type     len_n;
   logic [23:0] prefix_n;
   pos_type     pos_next;
   etl_rsp_type cand [3];
   logic [2:0]  cand_v;
   etl_rsp_type tok_b;
   logic        vb;
   etl_rsp_type grp [3];
   logic [1:0]  gcnt;
   idx_type     nchain [4];
   logic [15:0] num_ext;

   always_comb begin
      c        = in_ff.char_code;
      fin      = in_ff.end_of_text;
      ws       = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
      mode_n   = mode_ff;
      pend_n   = pend_ff;
      num_n    = num_ff;
      begin_n  = begin_ff;
      len_n    = len_ff;
      prefix_n = prefix_ff;
      cons     = 1'b0;
      cand[0]  = '0;
      cand_v   = '0;
      tok_b    = '0;
      vb       = 1'b0;
      pos_next = pos_inc(pos_ff);

      if (mode_ff == MODE_NUM && is_digit(c)) begin
         num_n = (num_ff << 3) + (num_ff << 1) + 32'(c - CH_ZERO);
         len_n = pos_inc(len_ff);
         cons  = 1'b1;
      end else if (mode_ff == MODE_IDENT && (is_alpha(c) || is_digit(c))) begin
         if (len_ff < pos_type'(3)) begin
            prefix_n = {prefix_ff[15:0], c};
         end
         len_n = pos_inc(len_ff);
         cons  = 1'b1;
      end else if (mode_ff == MODE_OP && c == op_second(pend_ff)) begin
         cand[0]   = make_tok(op_pair(pend_ff), begin_ff, 16'd2, 32'd0);
         cand_v[0] = 1'b1;
         mode_n    = MODE_IDLE;
         pend_n    = OP_NONE;
         cons      = 1'b1;
      end

      if (!cons) begin
         cand[0]   = flush_tok(mode_ff, pend_ff, num_ff, begin_ff, len_ff, prefix_ff);
         cand_v[0] = (mode_ff != MODE_IDLE);
         mode_n    = MODE_IDLE;
         pend_n    = OP_NONE;
         begin_n   = pos_ff;
         len_n     = pos_type'(1);
         if (ws) begin
            mode_n = MODE_IDLE;
         end else if (is_digit(c)) begin
            mode_n = MODE_NUM;
            num_n  = 32'(c - CH_ZERO);
         end else if (is_alpha(c)) begin
            mode_n   = MODE_IDENT;
            prefix_n = {16'd0, c};
         end else begin
            vb = 1'b1;
            unique case (c)
               CH_AMP:   begin vb = 1'b0; mode_n = MODE_OP; pend_n = OP_AMP;  end
               CH_BAR:   begin vb = 1'b0; mode_n = MODE_OP; pend_n = OP_BAR;  end
               CH_BANG:  begin vb = 1'b0; mode_n = MODE_OP; pend_n = OP_BANG; end
               CH_EQ:    begin vb = 1'b0; mode_n = MODE_OP; pend_n = OP_EQ;   end
               CH_LT:    begin vb = 1'b0; mode_n = MODE_OP; pend_n = OP_LT;   end
               CH_GT:    begin vb = 1'b0; mode_n = MODE_OP; pend_n = OP_GT;   end
               CH_LP:    tok_b = make_tok(K_LP, pos_ff, 16'd1, 32'd0);
               CH_RP:    tok_b = make_tok(K_RP, pos_ff, 16'd1, 32'd0);
               CH_PLUS:  tok_b = make_tok(K_PLUS, pos_ff, 16'd1, 32'd0);
               CH_MINUS: tok_b = make_tok(K_MINUS, pos_ff, 16'd1, 32'd0);
               CH_STAR:  tok_b = make_tok(K_STAR, pos_ff, 16'd1, 32'd0);
               CH_SLASH: tok_b = make_tok(K_SLASH, pos_ff, 16'd1, 32'd0);
               CH_PCT:   tok_b = make_tok(K_PCT, pos_ff, 16'd1, 32'd0);
               default:  tok_b = make_tok(K_ERR, pos_ff, 16'd1, 32'd0);
            endcase
         end
      end

      // an immediate token and a flushed pending token at end of text never coincide
      cand[1]   = vb ? tok_b
                     : flush_tok(mode_n, pend_n, num_n, begin_n, len_n, prefix_n);
      cand_v[1] = vb || (fin && mode_n != MODE_IDLE);
      cand[2]   = make_tok(K_EOF, pos_next, 16'd0, 32'd0);
      cand[2].is_final = 1'b1;
      cand_v[2] = fin;

      // pack the valid candidates in order and number them
      nchain[0] = tcnt_ff;
      for (int i = 0; i < 3; i++) begin
         nchain[i+1] = idx_inc(nchain[i]);
      end
      for (int i = 0; i < 3; i++) begin
         grp[i] = '0;
      end
      gcnt = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (cand_v[i]) begin
            num_ext                 = 16'(nchain[gcnt]);
            grp[gcnt]               = cand[i];
            grp[gcnt].token_number  = (num_ext > 16'd1023) ? 10'h3FF : num_ext[9:0];
            grp[gcnt].beyond_cap    = (num_ext >= 16'(cap_ff));
            gcnt                    = gcnt + 2'd1;
         end
      end
      num_ext = '0;
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      in_in       = req_xfer ? req_payload : in_ff;
      in_valid_in = req_xfer || (in_valid_ff && !process);
      cap_in      = csr_wr_en ? csr_wr_data : cap_ff;

      mode_in   = mode_ff;
      pend_in   = pend_ff;
      num_in    = num_ff;
      begin_in  = begin_ff;
      len_in    = len_ff;
      prefix_in = prefix_ff;
      pos_in    = pos_ff;
      tcnt_in   = tcnt_ff;
      if (process) begin
         if (fin) begin
            mode_in   = MODE_IDLE;
            pend_in   = OP_NONE;
            num_in    = '0;
            begin_in  = '0;
            len_in    = '0;
            prefix_in = '0;
            pos_in    = '0;
            tcnt_in   = '0;
         end else begin
            mode_in   = mode_n;
            pend_in   = pend_n;
            num_in    = num_n;
            begin_in  = begin_n;
            len_in    = len_n;
            prefix_in = prefix_n;
            pos_in    = pos_next;
            tcnt_in   = nchain[gcnt];
         end
      end

      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (process) begin
         buf_in = grp;
         cnt_in = gcnt;
      end else if (rsp_xfer) begin
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
         cnt_in    = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      buf_ff <= buf_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
         cap_ff      <= CAP_RESET;
         mode_ff     <= MODE_IDLE;
         pend_ff     <= OP_NONE;
         num_ff      <= '0;
         begin_ff    <= '0;
         len_ff      <= '0;
         prefix_ff   <= '0;
         pos_ff      <= '0;
         tcnt_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         cap_ff      <= cap_in;
         mode_ff     <= mode_in;
         pend_ff     <= pend_in;
         num_ff      <= num_in;
         begin_ff    <= begin_in;
         len_ff      <= len_in;
         prefix_ff   <= prefix_in;
         pos_ff      <= pos_in;
         tcnt_ff     <= tcnt_in;
      end
   end

endmodule
